// ===== rtl/core/vcl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcl_pkg
// Types and codes shared by the crown labeller top level and its seed cells.
// ----------------------------------------------------------------------------
package vcl_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_LOAD   = 2'd1,
        OP_SURVEY = 2'd2,
        OP_LABEL  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DROP  = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_PIXEL    = 3'd2,
        REG_ROWS     = 3'd3,
        REG_COLS     = 3'd4,
        REG_FACTOR   = 3'd5,
        REG_EXCL     = 3'd6
    } t_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_CALC,
        S_CHAIN,
        S_J1,
        S_J2,
        S_J3
    } t_state;

    // world coordinate of a cell centre, Q.8, and squared distance, Q.16
    localparam int CW   = 46;
    localparam int DW   = 93;
    localparam int IDXW = 12;

    typedef struct packed {
        logic                 tok;
        logic signed [CW-1:0] wx;
        logic signed [CW-1:0] wy;
    } t_query;

    typedef struct packed {
        logic             tok;
        logic             found;
        logic [DW-1:0]    d;
        logic [IDXW-1:0]  idx;
        logic [30:0]      id;
        logic signed [23:0] gm;
        logic             seen;
    } t_best;

    typedef struct packed {
        logic               clr;
        logic               ld;
        logic [IDXW-1:0]    ld_idx;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [30:0]        id;
        logic               gw;
        logic [IDXW-1:0]    g_idx;
        logic signed [23:0] gh;
    } t_wr;

endpackage

// ===== rtl/core/vcl_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcl_cell
// One seed slot: holds a seed and its group maximum, computes the squared
// distance to the passing query and hands the running nearest on.
// ----------------------------------------------------------------------------
module vcl_cell #(
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_used,
    input  vcl_pkg::t_query i_q,
    input  vcl_pkg::t_best  i_b,
    input  vcl_pkg::t_wr    i_wr,
    output vcl_pkg::t_query o_q,
    output vcl_pkg::t_best  o_b
);
    import vcl_pkg::*;

    logic signed [31:0] r_x, r_y;
    logic [30:0]        r_id;
    logic signed [23:0] r_gm;
    logic               r_seen;

    t_query             r_q;
    logic               r_tok_a, r_tok_b, r_tok_c, r_tok_d;
    logic [CW-1:0]      r_mx, r_my;
    logic [45:0]        r_xll, r_xlh, r_xhh, r_yll, r_ylh, r_yhh;
    logic [91:0]        r_sqx, r_sqy;
    logic [DW-1:0]      r_d;
    t_best              r_b, n_b;

    logic signed [CW:0] ex, ey;
    logic [CW-1:0]      mx, my;
    logic               take;

    always_comb begin
        ex = {i_q.wx[CW-1], i_q.wx} - (CW+1)'(r_x);
        ey = {i_q.wy[CW-1], i_q.wy} - (CW+1)'(r_y);
        mx = ex[CW] ? CW'(-ex) : ex[CW-1:0];
        my = ey[CW] ? CW'(-ey) : ey[CW-1:0];
    end

    // strict less keeps the lowest index on ties
    always_comb begin
        take = i_used && (!i_b.found || (r_d < i_b.d));
        n_b  = i_b;
        if (take) begin
            n_b.found = 1'b1;
            n_b.d     = r_d;
            n_b.idx   = IDXW'(IDX);
            n_b.id    = r_id;
            n_b.gm    = r_gm;
            n_b.seen  = r_seen;
        end
        n_b.tok = r_tok_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= 1'b0;
            r_q.tok <= 1'b0;
            r_tok_a <= 1'b0;
            r_tok_b <= 1'b0;
            r_tok_c <= 1'b0;
            r_tok_d <= 1'b0;
            r_b.tok <= 1'b0;
        end else begin
            if (i_wr.clr) begin
                r_seen <= 1'b0;
            end else if (i_wr.ld && i_wr.ld_idx == IDXW'(IDX)) begin
                r_seen <= 1'b0;
            end else if (i_wr.gw && i_wr.g_idx == IDXW'(IDX)) begin
                r_seen <= 1'b1;
            end
            r_q.tok <= i_q.tok;
            r_tok_a <= i_q.tok;
            r_tok_b <= r_tok_a;
            r_tok_c <= r_tok_b;
            r_tok_d <= r_tok_c;
            r_b.tok <= n_b.tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.ld && i_wr.ld_idx == IDXW'(IDX)) begin
            r_x  <= i_wr.x;
            r_y  <= i_wr.y;
            r_id <= i_wr.id;
        end
        if (i_wr.gw && i_wr.g_idx == IDXW'(IDX)) begin
            r_gm <= i_wr.gh;
        end
        r_q.wx <= i_q.wx;
        r_q.wy <= i_q.wy;
        r_mx   <= mx;
        r_my   <= my;
        // 23-bit halves keep each product small
        r_xll  <= 46'(r_mx[22:0])  * 46'(r_mx[22:0]);
        r_xlh  <= 46'(r_mx[22:0])  * 46'(r_mx[45:23]);
        r_xhh  <= 46'(r_mx[45:23]) * 46'(r_mx[45:23]);
        r_yll  <= 46'(r_my[22:0])  * 46'(r_my[22:0]);
        r_ylh  <= 46'(r_my[22:0])  * 46'(r_my[45:23]);
        r_yhh  <= 46'(r_my[45:23]) * 46'(r_my[45:23]);
        r_sqx  <= {r_xhh, 46'b0} + {21'b0, r_xlh, 24'b0} + {46'b0, r_xll};
        r_sqy  <= {r_yhh, 46'b0} + {21'b0, r_ylh, 24'b0} + {46'b0, r_yll};
        r_d    <= {1'b0, r_sqx} + {1'b0, r_sqy};
        r_b.found <= n_b.found;
        r_b.d     <= n_b.d;
        r_b.idx   <= n_b.idx;
        r_b.id    <= n_b.id;
        r_b.gm    <= n_b.gm;
        r_b.seen  <= n_b.seen;
    end

    assign o_q = r_q;
    assign o_b = r_b;

endmodule

// ===== rtl/core/voronoi_crown_labeller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voronoi_crown_labeller
// Labels canopy raster cells with the id of the nearest tree seed.
// ----------------------------------------------------------------------------
// One item at a time; busy stays high until the result strobe. Clear and load
// items end in S_CALC, as do survey and label items on no seeds or an
// out-of-bounds cell; others run the query through MAX_SEEDS seed cells, one
// cell per cycle, each with a registered distance pipeline, then S_J1 to S_J3
// (survey and unseen-group label items end in S_J1). The result is shown for
// one cycle only and cannot be held off, so it must be captured on the strobe.
module voronoi_crown_labeller #(
    parameter int MAX_SEEDS = 256,
    parameter int MAX_DIM   = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_opcode,
    input  logic signed [31:0] i_seed_x,
    input  logic signed [31:0] i_seed_y,
    input  logic [30:0]        i_seed_id,
    input  logic [11:0]        i_cell_row,
    input  logic [11:0]        i_cell_col,
    input  logic signed [23:0] i_cell_height,
    input  logic               i_cell_valid,
    output logic               o_done,
    output logic [30:0]        o_label,
    output logic [1:0]         o_status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import vcl_pkg::*;

    localparam int CNTW = $clog2(MAX_SEEDS + 1);
    localparam logic [16:0] DIM_CAP = 17'(MAX_DIM);

    // configuration
    logic signed [31:0] r_ox, r_oy;
    logic [30:0]        r_ps;
    logic [12:0]        r_rows, r_cols;
    logic [15:0]        r_cf, r_excl;

    // item
    t_op                r_op;
    logic signed [31:0] r_sx, r_sy;
    logic [30:0]        r_sid;
    logic [11:0]        r_row, r_col;
    logic signed [23:0] r_h;
    logic               r_cv;

    t_state             r_state, n_state;
    logic [CNTW-1:0]    r_count;
    logic [42:0]        r_pc, r_pr;
    logic signed [50:0] r_fx, r_fy;
    t_query             r_qin, n_qin;
    t_best              r_best;
    logic signed [40:0] r_tallp, r_fh;
    logic               r_tall, r_fneg;
    logic [39:0]        r_fll, r_flh, r_fhh;
    logic               r_done;
    logic [30:0]        r_label;
    logic [1:0]         r_status;

    t_query             q [0:MAX_SEEDS];
    t_best              b [0:MAX_SEEDS];
    logic [MAX_SEEDS-1:0] used;
    t_wr                wr;

    logic [16:0]        rows_e, cols_e;
    logic               cfg_wr, inb, fp_ok, full;
    logic signed [51:0] x2, y2, xmin2, xmax2, ymin2, ymax2;
    logic [80:0]        f2;
    logic               near;
    logic               fin;
    logic [30:0]        fin_label;
    t_status            fin_status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign busy   = (r_state != S_IDLE);

    always_comb begin
        prdata = '0;
        unique case (t_reg'(paddr[4:2]))
            REG_ORIGIN_X: prdata = r_ox;
            REG_ORIGIN_Y: prdata = r_oy;
            REG_PIXEL:    prdata = {1'b0, r_ps};
            REG_ROWS:     prdata = {19'b0, r_rows};
            REG_COLS:     prdata = {19'b0, r_cols};
            REG_FACTOR:   prdata = {16'b0, r_cf};
            REG_EXCL:     prdata = {16'b0, r_excl};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ox   <= '0;
            r_oy   <= '0;
            r_ps   <= 31'd256;
            r_rows <= 13'd1;
            r_cols <= 13'd1;
            r_cf   <= 16'd154;
            r_excl <= 16'd19661;
        end else if (cfg_wr) begin
            unique case (t_reg'(paddr[4:2]))
                REG_ORIGIN_X: r_ox   <= pwdata;
                REG_ORIGIN_Y: r_oy   <= pwdata;
                REG_PIXEL:    r_ps   <= pwdata[30:0];
                REG_ROWS:     r_rows <= pwdata[12:0];
                REG_COLS:     r_cols <= pwdata[12:0];
                REG_FACTOR:   r_cf   <= pwdata[15:0];
                REG_EXCL:     r_excl <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // dimensions above MAX_DIM saturate
    assign rows_e = ({4'b0, r_rows} > DIM_CAP) ? DIM_CAP : {4'b0, r_rows};
    assign cols_e = ({4'b0, r_cols} > DIM_CAP) ? DIM_CAP : {4'b0, r_cols};

    // footprint at doubled scale, half-pixel skirt included
    always_comb begin
        x2    = 52'(r_sx) <<< 1;
        y2    = 52'(r_sy) <<< 1;
        xmin2 = (52'(r_ox) <<< 1) - $signed({21'b0, r_ps});
        ymax2 = (52'(r_oy) <<< 1) + $signed({21'b0, r_ps});
        xmax2 = (52'(r_ox) <<< 1) + 52'(r_fx);
        ymin2 = (52'(r_oy) <<< 1) - 52'(r_fy);
        fp_ok = (r_sid != '0) && !(x2 < xmin2) && !(x2 > xmax2)
                && !(y2 < ymin2) && !(y2 > ymax2);
        full  = ({1'b0, r_count} >= (CNTW+1)'(MAX_SEEDS));
        inb   = r_cv && ({5'b0, r_row} < rows_e) && ({5'b0, r_col} < cols_e);
    end

    always_comb begin
        f2   = {r_fhh, 40'b0} + {20'b0, r_flh, 21'b0} + {41'b0, r_fll};
        near = !r_fneg && ({28'b0, f2} >= {r_best.d, 16'b0});
    end

    // ---------------- chain of seed cells ----------------
    assign q[0] = r_qin;
    assign b[0] = '0;

    genvar k;
    generate
        for (k = 0; k < MAX_SEEDS; k++) begin : g_cell
            assign used[k] = (CNTW'(k) < r_count);
            vcl_cell #(.IDX(k)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_used  (used[k]),
                .i_q     (q[k]),
                .i_b     (b[k]),
                .i_wr    (wr),
                .o_q     (q[k+1]),
                .o_b     (b[k+1])
            );
        end
    endgenerate

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (start) n_state = S_PREP;
            S_PREP:  n_state = S_CALC;
            S_CALC:  n_state = fin ? S_IDLE : S_CHAIN;
            S_CHAIN: if (b[MAX_SEEDS].tok) n_state = S_J1;
            S_J1:    n_state = fin ? S_IDLE : S_J2;
            S_J2:    n_state = S_J3;
            S_J3:    n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        fin        = 1'b0;
        fin_label  = '0;
        fin_status = ST_OK;
        n_qin      = '0;
        n_qin.wx   = $signed({r_ox[31], r_ox[31], r_ox[31], r_ox[31], r_ox[31],
                              r_ox[31], r_ox[31], r_ox[31], r_ox[31], r_ox[31],
                              r_ox[31], r_ox[31], r_ox[31], r_ox[31], r_ox})
                     + $signed({3'b0, r_pc});
        n_qin.wy   = CW'(r_oy) - $signed({3'b0, r_pr});
        wr         = '0;
        wr.ld_idx  = IDXW'(r_count);
        wr.x       = r_sx;
        wr.y       = r_sy;
        wr.id      = r_sid;
        wr.g_idx   = r_best.idx;
        wr.gh      = r_h;
        unique case (r_state)
            S_CALC: begin
                unique case (r_op)
                    OP_CLEAR: begin
                        fin    = 1'b1;
                        wr.clr = 1'b1;
                    end
                    OP_LOAD: begin
                        fin = 1'b1;
                        if (!fp_ok) begin
                            fin_status = ST_DROP;
                        end else if (full) begin
                            fin_status = ST_FULL;
                        end else begin
                            wr.ld = 1'b1;
                        end
                    end
                    OP_SURVEY, OP_LABEL: begin
                        if (r_count == '0) begin
                            fin        = 1'b1;
                            fin_status = ST_EMPTY;
                        end else if (!inb) begin
                            fin = 1'b1;
                        end else begin
                            n_qin.tok = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            S_J1: begin
                if (r_op == OP_SURVEY) begin
                    fin   = 1'b1;
                    wr.gw = !r_best.seen || (r_h > r_best.gm);
                end else if (!r_best.seen) begin
                    fin = 1'b1;
                end
            end
            S_J3: begin
                fin       = 1'b1;
                fin_label = (r_tall && near) ? r_best.id : '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_qin.tok <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_qin.tok <= n_qin.tok;
            r_done    <= fin;
            if (wr.clr) begin
                r_count <= '0;
            end else if (wr.ld) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_op  <= t_op'(i_opcode);
            r_sx  <= i_seed_x;
            r_sy  <= i_seed_y;
            r_sid <= i_seed_id;
            r_row <= i_cell_row;
            r_col <= i_cell_col;
            r_h   <= i_cell_height;
            r_cv  <= i_cell_valid;
        end
        r_pc <= 43'(r_col) * 43'(r_ps);
        r_pr <= 43'(r_row) * 43'(r_ps);
        r_fx <= 51'($signed({1'b0, cols_e, 1'b0}) - 19'sd1) * $signed({20'b0, r_ps});
        r_fy <= 51'($signed({1'b0, rows_e, 1'b0}) - 19'sd1) * $signed({20'b0, r_ps});
        r_qin.wx <= n_qin.wx;
        r_qin.wy <= n_qin.wy;
        if (r_state == S_CHAIN && b[MAX_SEEDS].tok) begin
            r_best <= b[MAX_SEEDS];
        end
        r_tallp <= $signed({1'b0, r_excl}) * r_best.gm;
        r_fh    <= $signed({1'b0, r_cf}) * r_best.gm;
        r_tall  <= (41'(r_h) <<< 16) >= r_tallp;
        r_fneg  <= r_fh[40];
        r_fll   <= 40'(r_fh[19:0])  * 40'(r_fh[19:0]);
        r_flh   <= 40'(r_fh[19:0])  * 40'(r_fh[39:20]);
        r_fhh   <= 40'(r_fh[39:20]) * 40'(r_fh[39:20]);
        if (fin) begin
            r_label  <= fin_label;
            r_status <= fin_status;
        end
    end

    assign o_done   = r_done;
    assign o_label  = r_label;
    assign o_status = r_status;

endmodule
